/* hdl/cartridge_sound_and_irq_unit_defines.svh */
// Assertion macros shared by the cartridge sound and IRQ unit.
`ifndef CARTRIDGE_SOUND_AND_IRQ_UNIT_DEFINES_SVH
`define CARTRIDGE_SOUND_AND_IRQ_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CSI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csi assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CSI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("csi assertion failed");

`endif

/* hdl/csi_pkg.sv */
// Types and constants shared by the cartridge sound and IRQ unit.
`timescale 1ns / 1ps
package csi_pkg;

  // Request kinds carried in the func field.
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_CPU   = 2'd1;
  localparam logic [1:0] FUNC_AUDIO = 2'd2;

  // Register select within a page, after the optional A0/A1 swap.
  localparam logic [1:0] REG_CTRL = 2'd0;
  localparam logic [1:0] REG_LOW  = 2'd1;
  localparam logic [1:0] REG_HIGH = 2'd2;
  localparam logic [1:0] REG_AUX  = 2'd3;

  // Upper address nibble of each mapped page.
  localparam logic [3:0] ADDR_PULSE_A = 4'h9;
  localparam logic [3:0] ADDR_PULSE_B = 4'hA;
  localparam logic [3:0] ADDR_SAW     = 4'hB;
  localparam logic [3:0] ADDR_IRQ     = 4'hF;

  localparam logic [8:0] PRESC_LIMIT   = 9'd338;
  localparam logic [8:0] PRESC_STEP    = 9'd3;
  localparam logic [7:0] COUNT_TOP     = 8'hFF;
  localparam logic [1:0] IRQ_DELAY     = 2'd1;
  localparam logic [3:0] SAW_STEP_WRAP = 4'd14;

  typedef enum logic [2:0] {
    PAGE_NONE,
    PAGE_PULSE_A,
    PAGE_PULSE_B,
    PAGE_SAW,
    PAGE_IRQ
  } page_e;

  // One decoded request, valid for the cycle in which it is applied.
  typedef struct packed {
    logic       wr;
    logic       cpu;
    logic       audio;
    page_e      page;
    logic [1:0] sel;
    logic [7:0] data;
  } cmd_t;

endpackage

/* hdl/cartridge_sound_and_irq_unit.sv */
// Top level: request register, address decode, mirroring and result handshake.
// A result is registered when its request leaves the request register.
// Throughput: one request per cycle if the result does not stall; the state
// update is a single pass from the request register into the channel and
// counter registers, which form the result and are held while it is stalled.
// Reset (async, active low) sets all but the request fields to defaults.
`timescale 1ns / 1ps
`include "cartridge_sound_and_irq_unit_defines.svh"
module cartridge_sound_and_irq_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  pulse_a_level_o,
  output logic [3:0]  pulse_b_level_o,
  output logic [7:0]  saw_level_o,
  output logic        irq_line_o,
  output logic [1:0]  mirror_select_o
);

  logic        revision_q;
  logic        s1_valid_q, s1_valid_d;
  logic [1:0]  s1_func_q;
  logic [15:0] s1_addr_q;
  logic [7:0]  s1_data_q;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  mirror_q, mirror_d;
  logic        accept;
  logic        advance;
  csi_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  // The held request moves on when the result slot is empty or being taken.
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    logic [1:0] sel;
    sel = s1_addr_q[1:0];
    if (revision_q) sel = {s1_addr_q[0], s1_addr_q[1]};
    cmd.wr    = advance && (s1_func_q == csi_pkg::FUNC_WRITE);
    cmd.cpu   = advance && (s1_func_q == csi_pkg::FUNC_CPU);
    cmd.audio = advance && (s1_func_q == csi_pkg::FUNC_AUDIO);
    cmd.sel   = sel;
    cmd.data  = s1_data_q;
    unique case (s1_addr_q[15:12])
      csi_pkg::ADDR_PULSE_A: cmd.page = csi_pkg::PAGE_PULSE_A;
      csi_pkg::ADDR_PULSE_B: cmd.page = csi_pkg::PAGE_PULSE_B;
      csi_pkg::ADDR_SAW:     cmd.page = csi_pkg::PAGE_SAW;
      csi_pkg::ADDR_IRQ:     cmd.page = csi_pkg::PAGE_IRQ;
      default:               cmd.page = csi_pkg::PAGE_NONE;
    endcase
  end

  always_comb begin
    mirror_d = mirror_q;
    if (cmd.wr && cmd.page == csi_pkg::PAGE_SAW && cmd.sel == csi_pkg::REG_AUX) begin
      mirror_d = cmd.data[3:2];
    end
    s1_valid_d = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
    out_valid_d = advance ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      revision_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mirror_q    <= '0;
    end else begin
      if (cfg_valid_i) revision_q <= cfg_data_i;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      mirror_q    <= mirror_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_func_q <= func_i;
      s1_addr_q <= address_i;
      s1_data_q <= data_i;
    end
  end

  csi_sound u_sound (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .pulse_a_level_o (pulse_a_level_o),
    .pulse_b_level_o (pulse_b_level_o),
    .saw_level_o     (saw_level_o)
  );

  csi_irq u_irq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .irq_line_o (irq_line_o)
  );

  assign out_valid_o     = out_valid_q;
  assign mirror_select_o = mirror_q;

  // The interrupt line only rises on a CPU tick request.
  `CSI_ASSERT_IMP(a_irq_rise_on_tick, $rose(irq_line_o), $past(cmd.cpu))
  // Writing the IRQ control or acknowledge register drops the line.
  `CSI_ASSERT_NXT(a_irq_clear_on_write,
    cmd.wr && cmd.page == csi_pkg::PAGE_IRQ &&
    (cmd.sel == csi_pkg::REG_LOW || cmd.sel == csi_pkg::REG_HIGH), !irq_line_o)
  // A held request waits while a stalled result occupies the output.
  `CSI_ASSERT_NXT(a_hold_behind_stall, s1_valid_q && out_valid_q && out_stall_i,
    s1_valid_q && out_valid_q)

endmodule

/* hdl/csi_sound.sv */
// Two pulse channels and the sawtooth channel, with their register writes.
`timescale 1ns / 1ps
module csi_sound (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  csi_pkg::cmd_t cmd_i,
  output logic [3:0]    pulse_a_level_o,
  output logic [3:0]    pulse_b_level_o,
  output logic [7:0]    saw_level_o
);

  logic        p_en_q     [2];
  logic [2:0]  p_duty_q   [2];
  logic [3:0]  p_step_q   [2];
  logic [3:0]  p_vol_q    [2];
  logic        p_const_q  [2];
  logic [11:0] p_period_q [2];
  logic [12:0] p_timer_q  [2];
  logic [3:0]  p_out_q    [2];
  logic        p_en_d     [2];
  logic [2:0]  p_duty_d   [2];
  logic [3:0]  p_step_d   [2];
  logic [3:0]  p_vol_d    [2];
  logic        p_const_d  [2];
  logic [11:0] p_period_d [2];
  logic [12:0] p_timer_d  [2];
  logic [3:0]  p_out_d    [2];

  logic        s_en_q, s_en_d;
  logic [5:0]  s_rate_q, s_rate_d;
  logic [3:0]  s_step_q, s_step_d;
  logic [7:0]  s_accum_q, s_accum_d;
  logic [11:0] s_period_q, s_period_d;
  logic [12:0] s_timer_q, s_timer_d;
  logic [7:0]  s_out_q, s_out_d;

  always_comb begin
    logic [12:0]       tdec;
    logic [3:0]        nstep;
    logic [7:0]        acc;
    csi_pkg::page_e    pg;
    tdec  = '0;
    nstep = '0;
    acc   = '0;
    pg    = csi_pkg::PAGE_NONE;
    for (int ch = 0; ch < 2; ch++) begin
      p_en_d[ch]     = p_en_q[ch];
      p_duty_d[ch]   = p_duty_q[ch];
      p_step_d[ch]   = p_step_q[ch];
      p_vol_d[ch]    = p_vol_q[ch];
      p_const_d[ch]  = p_const_q[ch];
      p_period_d[ch] = p_period_q[ch];
      p_timer_d[ch]  = p_timer_q[ch];
      p_out_d[ch]    = p_out_q[ch];
      pg = (ch == 0) ? csi_pkg::PAGE_PULSE_A : csi_pkg::PAGE_PULSE_B;
      if (cmd_i.wr && cmd_i.page == pg) begin
        unique case (cmd_i.sel)
          csi_pkg::REG_CTRL: begin
            p_vol_d[ch]   = cmd_i.data[3:0];
            p_duty_d[ch]  = cmd_i.data[6:4];
            p_const_d[ch] = cmd_i.data[7];
          end
          csi_pkg::REG_LOW: p_period_d[ch][7:0] = cmd_i.data;
          csi_pkg::REG_HIGH: begin
            p_period_d[ch][11:8] = cmd_i.data[3:0];
            p_en_d[ch]           = cmd_i.data[7];
          end
          default: ;
        endcase
      end
      if (cmd_i.audio) begin
        tdec = p_timer_q[ch] - 13'd1;
        p_timer_d[ch] = tdec;
        if (tdec == '0) begin
          nstep = p_step_q[ch] + 4'd1;
          p_step_d[ch]  = nstep;
          p_timer_d[ch] = {1'b0, p_period_q[ch]} + 13'd1;
          if (p_en_q[ch]) begin
            // The duty compare sees the step after it has advanced.
            p_out_d[ch] = (p_const_q[ch] || nstep <= {1'b0, p_duty_q[ch]}) ?
                          p_vol_q[ch] : 4'd0;
          end
        end
        if (!p_en_q[ch]) p_out_d[ch] = 4'd0;
      end
    end

    s_en_d     = s_en_q;
    s_rate_d   = s_rate_q;
    s_step_d   = s_step_q;
    s_accum_d  = s_accum_q;
    s_period_d = s_period_q;
    s_timer_d  = s_timer_q;
    s_out_d    = s_out_q;
    if (cmd_i.wr && cmd_i.page == csi_pkg::PAGE_SAW) begin
      unique case (cmd_i.sel)
        csi_pkg::REG_CTRL: s_rate_d = cmd_i.data[5:0];
        csi_pkg::REG_LOW:  s_period_d[7:0] = cmd_i.data;
        csi_pkg::REG_HIGH: begin
          s_period_d[11:8] = cmd_i.data[3:0];
          s_en_d           = cmd_i.data[7];
        end
        default: ;
      endcase
    end
    if (cmd_i.audio) begin
      tdec = s_timer_q - 13'd1;
      s_timer_d = tdec;
      if (tdec == '0) begin
        s_timer_d = {1'b0, s_period_q} + 13'd1;
        acc = s_accum_q;
        // The accumulator grows on every even nonzero step.
        if (s_step_q != '0 && !s_step_q[0]) acc = s_accum_q + {2'b00, s_rate_q};
        nstep = s_step_q + 4'd1;
        if (nstep == csi_pkg::SAW_STEP_WRAP) begin
          nstep = '0;
          acc   = '0;
        end
        s_step_d  = nstep;
        s_accum_d = acc;
        if (s_en_q) s_out_d = acc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int ch = 0; ch < 2; ch++) begin
        p_en_q[ch]     <= 1'b0;
        p_duty_q[ch]   <= 3'd1;
        p_step_q[ch]   <= '0;
        p_vol_q[ch]    <= '0;
        p_const_q[ch]  <= 1'b0;
        p_period_q[ch] <= '0;
        p_timer_q[ch]  <= 13'd1;
        p_out_q[ch]    <= '0;
      end
      s_en_q     <= 1'b0;
      s_rate_q   <= '0;
      s_step_q   <= '0;
      s_accum_q  <= '0;
      s_period_q <= '0;
      s_timer_q  <= 13'd1;
      s_out_q    <= '0;
    end else begin
      for (int ch = 0; ch < 2; ch++) begin
        p_en_q[ch]     <= p_en_d[ch];
        p_duty_q[ch]   <= p_duty_d[ch];
        p_step_q[ch]   <= p_step_d[ch];
        p_vol_q[ch]    <= p_vol_d[ch];
        p_const_q[ch]  <= p_const_d[ch];
        p_period_q[ch] <= p_period_d[ch];
        p_timer_q[ch]  <= p_timer_d[ch];
        p_out_q[ch]    <= p_out_d[ch];
      end
      s_en_q     <= s_en_d;
      s_rate_q   <= s_rate_d;
      s_step_q   <= s_step_d;
      s_accum_q  <= s_accum_d;
      s_period_q <= s_period_d;
      s_timer_q  <= s_timer_d;
      s_out_q    <= s_out_d;
    end
  end

  assign pulse_a_level_o = p_out_q[0];
  assign pulse_b_level_o = p_out_q[1];
  assign saw_level_o     = s_out_q;

endmodule

/* hdl/csi_irq.sv */
// Scanline and cycle IRQ counter with its delayed interrupt line.
`timescale 1ns / 1ps
module csi_irq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  csi_pkg::cmd_t cmd_i,
  output logic          irq_line_o
);

  logic       en_q, en_d;
  logic       en_ack_q, en_ack_d;
  logic       cyc_mode_q, cyc_mode_d;
  logic [7:0] reload_q, reload_d;
  logic [7:0] count_q, count_d;
  logic [8:0] presc_q, presc_d;
  logic [1:0] delay_q, delay_d;
  logic       irq_q, irq_d;

  always_comb begin
    logic step;
    en_d       = en_q;
    en_ack_d   = en_ack_q;
    cyc_mode_d = cyc_mode_q;
    reload_d   = reload_q;
    count_d    = count_q;
    presc_d    = presc_q;
    delay_d    = delay_q;
    irq_d      = irq_q;
    step       = 1'b0;

    if (cmd_i.wr && cmd_i.page == csi_pkg::PAGE_IRQ) begin
      unique case (cmd_i.sel)
        csi_pkg::REG_CTRL: reload_d = cmd_i.data;
        csi_pkg::REG_LOW: begin
          en_ack_d   = cmd_i.data[0];
          en_d       = cmd_i.data[1];
          cyc_mode_d = cmd_i.data[2];
          if (cmd_i.data[1]) begin
            presc_d = '0;
            count_d = reload_q;
          end
          irq_d = 1'b0;
        end
        csi_pkg::REG_HIGH: begin
          en_d  = en_ack_q;
          irq_d = 1'b0;
        end
        default: ;
      endcase
    end

    if (cmd_i.cpu) begin
      // A running delay finishes even if a write cleared the line meanwhile.
      if (delay_q != '0) begin
        delay_d = delay_q - 2'd1;
        if (delay_q == 2'd1) irq_d = 1'b1;
      end
      if (en_q) begin
        if (cyc_mode_q) begin
          step = 1'b1;
        end else if (presc_q < csi_pkg::PRESC_LIMIT) begin
          presc_d = presc_q + csi_pkg::PRESC_STEP;
        end else begin
          presc_d = presc_q - csi_pkg::PRESC_LIMIT;
          step    = 1'b1;
        end
      end
      if (step) begin
        if (count_q != csi_pkg::COUNT_TOP) begin
          count_d = count_q + 8'd1;
        end else begin
          count_d = reload_q;
          delay_d = csi_pkg::IRQ_DELAY;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q       <= 1'b0;
      en_ack_q   <= 1'b0;
      cyc_mode_q <= 1'b0;
      reload_q   <= '0;
      count_q    <= '0;
      presc_q    <= '0;
      delay_q    <= '0;
      irq_q      <= 1'b0;
    end else begin
      en_q       <= en_d;
      en_ack_q   <= en_ack_d;
      cyc_mode_q <= cyc_mode_d;
      reload_q   <= reload_d;
      count_q    <= count_d;
      presc_q    <= presc_d;
      delay_q    <= delay_d;
      irq_q      <= irq_d;
    end
  end

  assign irq_line_o = irq_q;

endmodule
